FILE: sv/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  // downstream queue size, free space above it counts as this much
  localparam int QUEUE_BYTES = 2048;

  localparam int BYTE_W      = 8;
  localparam int ROOM_W      = 12;
  localparam int COUNT_W     = 9;
  localparam int SIZE_W      = 10;
  localparam int BAD_W       = 3;
  localparam int ROOM_EXT_W  = 17;
  localparam int KIND_W      = 2;
  localparam int VERDICT_W   = 2;

  // special bytes
  localparam logic [BYTE_W-1:0] SOF_BYTE   = 8'h01;
  localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'h06;
  localparam logic [BYTE_W-1:0] NAK_BYTE   = 8'h15;
  localparam logic [BYTE_W-1:0] CAN_BYTE   = 8'h18;
  localparam logic [BYTE_W-1:0] CHECK_INIT = 8'hFF;

  localparam logic [SIZE_W-1:0] MIN_FRAME  = 10'd3;
  localparam logic [SIZE_W-1:0] LEN_EXTRA  = 10'd2;
  localparam logic [BAD_W-1:0]  BAD_MAX    = 3'd7;
  localparam logic [BAD_W-1:0]  BAD_LIMIT  = 3'd3;

  // byte kinds
  localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONTROL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PROG    = 2'd3;

  // frame verdicts
  localparam logic [VERDICT_W-1:0] VERDICT_NONE      = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT    = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_MALFORMED = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DROPPED   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic [ROOM_W-1:0] queue_room;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic [KIND_W-1:0]    byte_kind;
    logic [VERDICT_W-1:0] verdict;
    logic                 chip_reset;
  } result_t;

endpackage

FILE: sv/sfr_input_stage.sv
`timescale 1ns / 1ps

module sfr_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     rx_byte,
  input  logic [11:0]    queue_room,
  input  logic           advance,
  output logic           hold_valid,
  output sfr_pkg::item_t hold_item
);
  import sfr_pkg::*;

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_item.rx_byte    <= rx_byte;
      hold_item.queue_room <= queue_room;
    end
  end

endmodule

FILE: sv/sfr_frame_engine.sv
`timescale 1ns / 1ps

module sfr_frame_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             programming_mode,
  input  logic             step,
  input  sfr_pkg::item_t   item,
  output sfr_pkg::result_t result
);
  import sfr_pkg::*;

  logic [COUNT_W-1:0]    byte_count, byte_count_next;
  logic [BYTE_W-1:0]     frame_length, frame_length_next;
  logic [BYTE_W-1:0]     running_check, running_check_next;
  logic [BAD_W-1:0]      bad_frame_count, bad_frame_count_next;

  logic [BYTE_W-1:0]     len_now;
  logic [SIZE_W-1:0]     size;
  logic [SIZE_W-1:0]     total;
  logic [SIZE_W-1:0]     idx_inc;
  logic [ROOM_EXT_W-1:0] room_ext;
  logic [ROOM_EXT_W-1:0] room;
  logic [BAD_W-1:0]      bad_inc;

  // length byte is taken straight from the held word on the second frame byte
  assign len_now  = (byte_count == COUNT_W'(1)) ? item.rx_byte : frame_length;
  assign size     = SIZE_W'(len_now) + LEN_EXTRA;
  assign total    = (size < MIN_FRAME) ? MIN_FRAME : size;
  assign idx_inc  = SIZE_W'(byte_count) + SIZE_W'(1);
  assign room_ext = ROOM_EXT_W'(item.queue_room);
  assign room     = (room_ext > ROOM_EXT_W'(QUEUE_BYTES)) ? ROOM_EXT_W'(QUEUE_BYTES)
                                                         : room_ext;
  assign bad_inc  = (bad_frame_count < BAD_MAX) ? bad_frame_count + BAD_W'(1)
                                                : bad_frame_count;

  always_comb begin
    byte_count_next      = byte_count;
    frame_length_next    = frame_length;
    running_check_next   = running_check;
    bad_frame_count_next = bad_frame_count;
    result.data_byte     = item.rx_byte;
    result.byte_kind     = KIND_DISCARD;
    result.verdict       = VERDICT_NONE;
    result.chip_reset    = 1'b0;

    if (programming_mode) begin
      result.byte_kind = KIND_PROG;
    end else if (byte_count == '0) begin
      if (item.rx_byte == SOF_BYTE) begin
        result.byte_kind   = KIND_FRAME;
        byte_count_next    = COUNT_W'(1);
        running_check_next = CHECK_INIT;
      end else if (item.rx_byte == ACK_BYTE || item.rx_byte == NAK_BYTE ||
                   item.rx_byte == CAN_BYTE) begin
        result.byte_kind = KIND_CONTROL;
      end
    end else begin
      result.byte_kind  = KIND_FRAME;
      frame_length_next = len_now;
      if (idx_inc < total) begin
        running_check_next = running_check ^ item.rx_byte;
        byte_count_next    = idx_inc[COUNT_W-1:0];
      end else begin
        if (room < ROOM_EXT_W'(size)) begin
          result.verdict = VERDICT_DROPPED;
        end else if (size >= MIN_FRAME && running_check == item.rx_byte) begin
          result.verdict       = VERDICT_ACCEPT;
          bad_frame_count_next = '0;
        end else begin
          result.verdict       = VERDICT_MALFORMED;
          bad_frame_count_next = bad_inc;
          result.chip_reset    = (bad_inc > BAD_LIMIT);
        end
        byte_count_next    = '0;
        running_check_next = CHECK_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      frame_length    <= '0;
      running_check   <= CHECK_INIT;
      bad_frame_count <= '0;
    end else if (step) begin
      byte_count      <= byte_count_next;
      frame_length    <= frame_length_next;
      running_check   <= running_check_next;
      bad_frame_count <= bad_frame_count_next;
    end
  end

endmodule

FILE: sv/serial_frame_receiver_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | word
// --------+-----------+-----------------------+---------------------------------------
// in      | in        | in_valid / in_ready   | rx_byte, queue_room
// out     | out       | out_valid / out_ready | data_byte, byte_kind, verdict, chip_reset
// cfg     | in        | cfg_valid / cfg_ready | programming_mode
//
// one word in and one word out per cycle while out_ready stays high; a word that is taken passes
// the input register, then the result register, set by the single frame engine step
// rst (synchronous) empties both registers, leaves the receiver idle with the check at
// 0xff, bad frame count zero and regular mode selected
// a stall on out_ready holds the result register; in_ready then falls only once the
// input register also holds a word, so one word can wait behind a pending result
module serial_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic [11:0] queue_room,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [1:0]  byte_kind,
  output logic [1:0]  verdict,
  output logic        chip_reset,
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        programming_mode
);
  import sfr_pkg::*;

  logic    mode;        // current mode register
  logic    out_load;    // result register free or being emptied this cycle
  logic    hold_valid;  // input register holds a word
  logic    step;        // word moves from input register through the engine
  item_t   hold_item;
  result_t res;

  // mode register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= programming_mode;
    end
  end

  assign out_load = !out_valid || out_ready;
  assign step     = hold_valid && out_load;

  // input register
  sfr_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .queue_room (queue_room),
    .advance    (out_load),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // framing, checksum and verdict logic with the receiver state
  sfr_frame_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .programming_mode (mode),
    .step             (step),
    .item             (hold_item),
    .result           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_byte  <= res.data_byte;
      byte_kind  <= res.byte_kind;
      verdict    <= res.verdict;
      chip_reset <= res.chip_reset;
    end
  end

endmodule

FILE: dv/tb_serial_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_serial_frame_receiver_top;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;

  // tracks the receiver state and holds the reports due on the output, oldest first
  class frame_verdict_board;
    logic             prog_mode;
    logic [8:0]       frame_pos;
    logic [7:0]       frame_len;
    logic [7:0]       check_acc;
    logic [2:0]       bad_frames;
    result_t          due_reports[$];
    int               errors;

    function new();
      prog_mode  = 1'b0;
      frame_pos  = '0;
      frame_len  = '0;
      check_acc  = CHECK_INIT;
      bad_frames = '0;
      errors     = 0;
    endfunction

    function void set_mode(logic m);
      prog_mode = m;
    endfunction

    // work out the report for one accepted word
    function void note_byte(logic [7:0] b, logic [11:0] r);
      result_t rep;
      int room;
      int size;
      int span;
      room = (int'(r) > QUEUE_BYTES) ? QUEUE_BYTES : int'(r);
      rep.data_byte  = b;
      rep.byte_kind  = KIND_DISCARD;
      rep.verdict    = VERDICT_NONE;
      rep.chip_reset = 1'b0;
      if (prog_mode) begin
        rep.byte_kind = KIND_PROG;
      end else if (frame_pos == 0) begin
        if (b == SOF_BYTE) begin
          rep.byte_kind = KIND_FRAME;
          frame_pos = 9'd1;
          check_acc = CHECK_INIT;
        end else if (b == ACK_BYTE || b == NAK_BYTE || b == CAN_BYTE) begin
          rep.byte_kind = KIND_CONTROL;
        end
      end else begin
        rep.byte_kind = KIND_FRAME;
        if (frame_pos == 1) frame_len = b;
        size = int'(frame_len) + int'(LEN_EXTRA);
        span = (size < int'(MIN_FRAME)) ? int'(MIN_FRAME) : size;
        if (int'(frame_pos) + 1 < span) begin
          check_acc = check_acc ^ b;
          frame_pos = frame_pos + 9'd1;
        end else begin
          if (room < size) begin
            rep.verdict = VERDICT_DROPPED;
          end else if (size >= int'(MIN_FRAME) && check_acc == b) begin
            rep.verdict = VERDICT_ACCEPT;
            bad_frames = '0;
          end else begin
            rep.verdict = VERDICT_MALFORMED;
            if (bad_frames < BAD_MAX) bad_frames = bad_frames + 3'd1;
            if (bad_frames > BAD_LIMIT) rep.chip_reset = 1'b1;
          end
          frame_pos = '0;
          check_acc = CHECK_INIT;
        end
      end
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned wanted, int unsigned seen);
      if (wanted != seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, wanted, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected word, actual %0h", $time, got);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_kind", want.byte_kind, got.byte_kind);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("chip_reset", want.chip_reset, got.chip_reset);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic [11:0] queue_room = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_byte;
  logic [1:0]  byte_kind;
  logic [1:0]  verdict;
  logic        chip_reset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        programming_mode = 1'b0;

  // idling controls, set per phase
  bit send_gaps = 1'b0;
  bit stall_on  = 1'b0;
  bit calm      = 1'b0;
  int bytes_sent = 0;
  int cycles = 0;

  frame_verdict_board board;

  serial_frame_receiver_top uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .rx_byte          (rx_byte),
    .queue_room       (queue_room),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_byte        (data_byte),
    .byte_kind        (byte_kind),
    .verdict          (verdict),
    .chip_reset       (chip_reset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .programming_mode (programming_mode)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // handshake monitor: mode writes, accepted words in, reports out
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_mode(programming_mode);
      if (in_valid && in_ready) board.note_byte(rx_byte, queue_room);
      if (out_valid && out_ready) board.check_result({data_byte, byte_kind, verdict, chip_reset});
    end
  end

  // receiving side, stalls in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && !calm && !rst && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays high between back-to-back words, only dropped for a gap
  task automatic send_byte(input logic [7:0] b, input logic [11:0] r);
    if (send_gaps && !calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    queue_room <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid        <= 1'b1;
    programming_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame with random payload; room on the last byte decides drop or keep
  task automatic send_frame(input int len, input bit corrupt, input bit roomy);
    logic [7:0]  chk;
    logic [7:0]  pay;
    logic [11:0] room;
    int size;
    size = len + 2;
    chk = CHECK_INIT ^ 8'(len);
    send_byte(SOF_BYTE, 12'($urandom_range(0, 4095)));
    send_byte(8'(len), 12'($urandom_range(0, 4095)));
    for (int i = 1; i < len; i++) begin
      pay = 8'($urandom_range(0, 255));
      chk = chk ^ pay;
      send_byte(pay, 12'($urandom_range(0, 4095)));
    end
    if (len == 0) chk = 8'($urandom_range(0, 255));
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    if (roomy) begin
      room = 12'($urandom_range(size, 4095));
    end else begin
      case ($urandom_range(0, 9))
        0:       room = 12'(size - 1);
        1:       room = 12'(size);
        2:       room = 12'($urandom_range(0, 4095));
        3:       room = 12'($urandom_range(QUEUE_BYTES + 1, 4095));
        default: room = 12'($urandom_range(size, QUEUE_BYTES));
      endcase
    end
    send_byte(chk, room);
  endtask

  // mostly well formed frames, some runs of bad ones, some line noise
  task automatic run_regular(input int count);
    int stop;
    int pick;
    int len;
    logic [7:0] noise;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // run of bad frames, drives the count past the reset threshold and at times to saturation
        repeat ($urandom_range(4, 9)) send_frame($urandom_range(0, 3), 1'b1, 1'b1);
      end else if (pick < 26) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 5))
            0:       noise = ACK_BYTE;
            1:       noise = NAK_BYTE;
            2:       noise = CAN_BYTE;
            default: noise = 8'($urandom_range(0, 255));
          endcase
          send_byte(noise, 12'($urandom_range(0, 4095)));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick == 0)      len = $urandom_range(128, 255);
        else if (pick < 6)  len = 0;
        else if (pick < 30) len = $urandom_range(1, 2);
        else                len = $urandom_range(3, 12);
        send_frame(len, $urandom_range(0, 7) == 0, 1'b0);
      end
    end
  endtask

  task automatic run_programming(input int count);
    logic [7:0] b;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0:       b = SOF_BYTE;
        1:       b = ACK_BYTE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b0);
    settle();

    // control bytes and idle junk
    send_byte(ACK_BYTE, 12'd2048);
    send_byte(NAK_BYTE, 12'd2048);
    send_byte(CAN_BYTE, 12'd2048);
    send_byte(8'h00, 12'd0);
    send_byte(8'hFF, 12'hFFF);
    // shortest good frame, room exactly enough
    send_byte(SOF_BYTE, 12'd0);
    send_byte(8'h01, 12'hFFF);
    send_byte(8'hFE, 12'd3);
    // zero length, malformed even with a matching check
    send_byte(SOF_BYTE, 12'd2048);
    send_byte(8'h00, 12'd2048);
    send_byte(8'hFF, 12'd2);
    // good frame but one byte short of room
    send_byte(SOF_BYTE, 12'd2048);
    send_byte(8'h01, 12'd2048);
    send_byte(8'hFE, 12'd2);
    // wrong check
    send_byte(SOF_BYTE, 12'd2048);
    send_byte(8'h02, 12'd2048);
    send_byte(8'hAA, 12'd2048);
    send_byte(8'h00, 12'hFFF);
    // partial frame held across programming mode
    send_byte(SOF_BYTE, 12'd2048);
    send_byte(8'h02, 12'd2048);
    settle();
    write_mode(1'b1);
    send_byte(SOF_BYTE, 12'd0);
    send_byte(8'hFF, 12'hFFF);
    settle();
    write_mode(1'b0);
    send_byte(8'h55, 12'd2048);
    send_byte(CHECK_INIT ^ 8'h02 ^ 8'h55, 12'd2048);
    settle();

    // random phases, idling varied per phase
    send_gaps = 1'b1;
    stall_on  = 1'b1;
    send_frame(200, 1'b0, 1'b1);
    run_regular(220);
    settle();
    write_mode(1'b1);
    stall_on = 1'b0;
    run_programming(40);
    settle();
    write_mode(1'b0);
    send_gaps = 1'b0;
    stall_on  = 1'b1;
    run_regular(220);
    settle();
    write_mode(1'b1);
    send_gaps = 1'b1;
    run_programming(30);
    settle();
    write_mode(1'b0);
    run_regular(130);
    // closing stretch at full rate
    calm = 1'b1;
    run_regular(110);

    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.due_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
